[rtl/core/stable_priority_queue_macros.svh]
// assertion macros shared by the priority queue rtl
// no dependencies; the simulation forms are left out when SYNTHESIS is set
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spq assertion failed");
// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spq assertion failed");
`else
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/core/spq_pkg.sv]
// types and codes for the stable priority queue
// no dependencies; used by every module of the block
package spq_pkg;

   // operation codes
   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] data_in;
      logic [7:0]         priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data_out;
      logic [4:0]         occupancy;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       insert;
      logic       remove;
      logic       capture;
      logic [1:0] result_code;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_dequeue;
      logic full;
      logic empty;
   } stat_type;

endpackage

[rtl/core/spq_datapath.sv]
// entry store with parallel compare-and-shift, count and result register
// depends on spq_pkg and stable_priority_queue_macros.svh
`include "stable_priority_queue_macros.svh"

module spq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  spq_pkg::req_type req_item,
   input  spq_pkg::cmd_type cmd,
   output spq_pkg::stat_type stat,
   output spq_pkg::rsp_type rsp_item
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   req_type            req_ff;
   logic signed [31:0] ent_data_ff [DEPTH];
   logic [7:0]         ent_prio_ff [DEPTH];
   logic signed [31:0] ent_data_in [DEPTH];
   logic [7:0]         ent_prio_in [DEPTH];
   logic [DEPTH-1:0]   le;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   // latch the request on transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
   end

   // per-slot compare: stored, and priority number not above the new one
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le[i] = (CNT_W'(i) < count_ff) && (ent_prio_ff[i] <= req_ff.priority_req);
      end
   end

   // next slot contents: hold, take new entry, shift up or shift down
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_data_in[i] = ent_data_ff[i];
         ent_prio_in[i] = ent_prio_ff[i];
      end
      if (cmd.insert) begin
         if (!le[0]) begin
            ent_data_in[0] = req_ff.data_in;
            ent_prio_in[0] = req_ff.priority_req;
         end
         for (int i = 1; i < DEPTH; i++) begin
            if (!le[i]) begin
               if (le[i-1]) begin
                  ent_data_in[i] = req_ff.data_in;
                  ent_prio_in[i] = req_ff.priority_req;
               end else begin
                  ent_data_in[i] = ent_data_ff[i-1];
                  ent_prio_in[i] = ent_prio_ff[i-1];
               end
            end
         end
      end else if (cmd.remove) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            ent_data_in[i] = ent_data_ff[i+1];
            ent_prio_in[i] = ent_prio_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_data_ff[i] <= ent_data_in[i];
         ent_prio_ff[i] <= ent_prio_in[i];
      end
   end

   // occupancy count
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result register, occupancy taken after the operation
   always_comb begin
      rsp_in.status    = cmd.result_code;
      rsp_in.data_out  = cmd.remove ? ent_data_ff[0] : 32'sd0;
      rsp_in.occupancy = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item        = rsp_ff;
   assign stat.is_dequeue = (req_ff.kind == KIND_DEQUEUE);
   assign stat.full       = (count_ff == CNT_W'(DEPTH));
   assign stat.empty      = (count_ff == '0);

   // checks
   `SPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `SPQ_ASSERT_NOW(a_insert_not_full, clock, reset, cmd.insert, !stat.full)
   `SPQ_ASSERT_NEXT(a_insert_count, clock, reset, cmd.insert, count_ff == $past(count_ff) + 1'b1)
   `SPQ_ASSERT_NEXT(a_remove_count, clock, reset, cmd.remove, count_ff == $past(count_ff) - 1'b1)

endmodule

[rtl/core/spq_ctrl.sv]
// controller state machine: accepts a request, issues the operation, strobes the result
// depends on spq_pkg and stable_priority_queue_macros.svh
`include "stable_priority_queue_macros.svh"

module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  spq_pkg::stat_type stat,
   output logic              busy,
   output logic              rsp_valid,
   output spq_pkg::cmd_type  cmd
);
   import spq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd.load        = 1'b0;
      cmd.insert      = 1'b0;
      cmd.remove      = 1'b0;
      cmd.capture     = 1'b0;
      cmd.result_code = STATUS_OK;
      busy            = 1'b1;
      rsp_valid       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.capture = 1'b1;
            if (stat.is_dequeue) begin
               cmd.remove      = !stat.empty;
               cmd.result_code = stat.empty ? STATUS_UNDERFLOW : STATUS_OK;
            end else begin
               cmd.insert      = !stat.full;
               cmd.result_code = stat.full ? STATUS_OVERFLOW : STATUS_OK;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // checks
   `SPQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `SPQ_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `SPQ_ASSERT_NOW(a_one_op, clock, reset, cmd.insert || cmd.remove, cmd.capture && !(cmd.insert && cmd.remove))

endmodule

[rtl/core/stable_priority_queue.sv]
// stable priority queue, top level
// usage:
//   pulse start with req_item while busy is low; that edge is the request transfer.
//   req_item.kind selects enqueue or dequeue; lower priority_req is served first,
//   and equal priorities leave in arrival order.
//   every request gives one result on rsp_item, strobed by rsp_valid for one cycle;
//   the receiver takes it at that edge and cannot stall it.
//   status reports ok, underflow (dequeue when empty) or overflow (enqueue when full,
//   entry dropped); data_out holds the dequeued data, else zero; occupancy is the
//   entry count after the operation, low five bits.
// sequence:
//   the controller steps through idle, exec and done: the transfer edge latches the
//   request, exec does the parallel compare-and-shift over all slots and registers
//   the result, and done strobes rsp_valid; busy falls at the result transfer edge,
//   so a new request is taken only after the previous result has been delivered.
// reset:
//   synchronous reset empties the queue and returns the controller to idle;
//   stored slot contents are not cleared.
// depends on spq_pkg, spq_ctrl and spq_datapath
module stable_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_item,
   output logic             rsp_valid,
   output spq_pkg::rsp_type rsp_item
);
   import spq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // controller
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // entry store and result register
   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

endmodule

[tb/testbench.sv]
// self-checking testbench for stable_priority_queue
// depends on spq_pkg and the stable_priority_queue rtl; keeps its own sorted-list mirror
`timescale 1ns / 100ps

module testbench;
   import spq_pkg::*;

   localparam int DEPTH     = 16;
   localparam int RAND_OPS  = 1500;
   localparam int MAX_SHOWN = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   stable_priority_queue #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // sorted-list mirror of the queue plus the results it owes
   class pq_mirror;
      logic signed [31:0] slot_data [DEPTH];
      logic [7:0]         slot_prio [DEPTH];
      int                 slot_count = 0;
      rsp_type            awaited_rsp [$];
      int unsigned        fail_count = 0;

      // apply one accepted request and queue the result it must give
      function void note_request(req_type r);
         rsp_type e;
         int      pos;
         e.status   = STATUS_OK;
         e.data_out = '0;
         if (r.kind == KIND_ENQUEUE) begin
            if (slot_count >= DEPTH) begin
               e.status = STATUS_OVERFLOW;
            end else begin
               // insert after every entry of equal or smaller priority number
               pos = 0;
               while (pos < slot_count && slot_prio[pos] <= r.priority_req) pos++;
               for (int i = slot_count; i > pos; i--) begin
                  slot_data[i] = slot_data[i-1];
                  slot_prio[i] = slot_prio[i-1];
               end
               slot_data[pos] = r.data_in;
               slot_prio[pos] = r.priority_req;
               slot_count++;
            end
         end else if (slot_count == 0) begin
            e.status = STATUS_UNDERFLOW;
         end else begin
            // pop the front and close the gap
            e.data_out = slot_data[0];
            for (int i = 1; i < slot_count; i++) begin
               slot_data[i-1] = slot_data[i];
               slot_prio[i-1] = slot_prio[i];
            end
            slot_count--;
         end
         e.occupancy = 5'(slot_count);
         awaited_rsp.push_back(e);
      endfunction

      // compare one result transfer against the oldest expectation
      function void check_result(rsp_type got);
         rsp_type e;
         if (awaited_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display("%0t: result with none pending: status %0d data %0d occ %0d",
                        $realtime, got.status, got.data_out, got.occupancy);
            return;
         end
         e = awaited_rsp.pop_front();
         if (got.status !== e.status || got.data_out !== e.data_out ||
             got.occupancy !== e.occupancy) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display("%0t: mismatch exp status %0d data %0d occ %0d, got %0d %0d %0d",
                        $realtime, e.status, e.data_out, e.occupancy,
                        got.status, got.data_out, got.occupancy);
         end
      endfunction
   endclass

   pq_mirror board = new();

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watch both channels; the result is checked before a request in the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_result(rsp_item);
         if (start && !busy) board.note_request(req_item);
      end
   end

   // present one request and hold it until the transfer edge
   task automatic send_request(req_type item);
      bit taken;
      start    <= 1'b1;
      req_item <= item;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   function automatic req_type make_req(logic kind, logic signed [31:0] data,
                                        logic [7:0] prio);
      req_type r;
      r.kind         = kind;
      r.data_in      = data;
      r.priority_req = prio;
      return r;
   endfunction

   // stimulus
   initial begin
      logic [7:0]         fill_prio [16];
      logic signed [31:0] fill_data;
      req_type            item;
      int                 bias;
      int                 burst;
      int                 gap;
      int                 sent;
      bit                 drained_once;

      fill_prio = '{8'd5, 8'd5, 8'd0, 8'd255, 8'd5, 8'd3, 8'd255, 8'd0,
                    8'd5, 8'd128, 8'd3, 8'd5, 8'd1, 8'd255, 8'd7, 8'd0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // dequeue on empty queue gives underflow
      send_request(make_req(KIND_DEQUEUE, 32'sh7fffffff, 8'hff));
      // fill with ties and extreme priorities and data
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            0:       fill_data = 32'sh7fffffff;
            1:       fill_data = 32'sh80000000;
            2:       fill_data = 32'sh00000000;
            3:       fill_data = 32'shffffffff;
            default: fill_data = $urandom;
         endcase
         send_request(make_req(KIND_ENQUEUE, fill_data, fill_prio[i]));
      end
      // enqueue on full queue is dropped
      send_request(make_req(KIND_ENQUEUE, 32'sh12345678, 8'd0));
      for (int i = 0; i < 6; i++)
         send_request(make_req(KIND_DEQUEUE, 32'sh0, 8'd0));
      start <= 1'b0;
      @(posedge clock);

      // random bursts with shifting enqueue bias so the queue swings full and empty
      sent = 0;
      bias = 50;
      drained_once = 0;
      while (sent < RAND_OPS) begin
         burst = $urandom_range(1, 24);
         for (int b = 0; b < burst && sent < RAND_OPS; b++) begin
            if (sent % 60 == 0) begin
               case ($urandom_range(2))
                  0:       bias = 15;
                  1:       bias = 50;
                  default: bias = 85;
               endcase
            end
            item.kind         = ($urandom_range(99) < bias) ? KIND_ENQUEUE : KIND_DEQUEUE;
            item.data_in      = $urandom;
            item.priority_req = $urandom_range(1) ? 8'($urandom_range(3))
                                                  : 8'($urandom_range(255));
            send_request(item);
            sent++;
         end
         // one full drain halfway through; step an edge first so the last transfer is noted
         if (!drained_once && sent >= RAND_OPS / 2) begin
            start <= 1'b0;
            do @(posedge clock); while (board.awaited_rsp.size() != 0);
            drained_once = 1;
         end
         gap = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      start <= 1'b0;

      // let the last results arrive, then idle on and check that no result is still owed
      do @(posedge clock); while (board.awaited_rsp.size() != 0);
      repeat (8) @(posedge clock);
      if (board.awaited_rsp.size() != 0) board.fail_count++;
      if (board.fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // timeout guard
   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_datapath.sv
rtl/core/spq_ctrl.sv
rtl/core/stable_priority_queue.sv
tb/testbench.sv
